/* rtl/fic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_pkg
// Shared constants, tables and types of the fuzzy image compare block.
// ----------------------------------------------------------------------------
package fic_pkg;

  // default parameter values
  localparam int MAX_PIXELS_LOG2_DEF = 22;
  localparam int LAB_FRAC_BITS_DEF   = 8;

  // register map (index = paddr[3:2])
  localparam logic [1:0] REG_DELTA_E = 2'd0;
  localparam logic [1:0] REG_RMS     = 2'd1;
  localparam logic [1:0] REG_DRIFT   = 2'd2;

  localparam logic [15:0] DELTA_E_RST = 16'd512;
  localparam logic [15:0] RMS_RST     = 16'd1280;
  localparam logic [14:0] DRIFT_RST   = 15'd256;

  // linear light, Q1.16 with 1.0 = 65536
  localparam int LIN_W = 17;
  // Lab component width, signed, wide enough for 12 fraction bits
  localparam int LAB_W = 26;

  typedef logic [LIN_W-1:0] lin_t;
  typedef lin_t gamma_tab_t [256];
  typedef logic signed [LAB_W-1:0] lab_t;
  typedef lab_t lab_vec_t [3];

  // result of one delta E judgement
  typedef struct packed {
    logic done;
    logic mismatch;
  } judge_t;

  // sRGB to XYZ over the white point, Q0.15, rows X, Y, Z
  localparam logic [14:0] MAT_COEF [3][3] = '{
    '{15'd14218, 15'd12328, 15'd6223},
    '{15'd6966,  15'd23436, 15'd2366},
    '{15'd581,   15'd3587,  15'd28605}
  };

  // gamma expansion table, built at elaboration
  function automatic gamma_tab_t build_gamma();
    gamma_tab_t  tab;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] p;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        tab[v] = LIN_W'((64'(v) * 64'd6553600 + 64'd164730) / 64'd329460);
      end else begin
        t = ((64'(1000 * v + 14025) << 24) + 64'd134512) / 64'd269025;
        u = (t * t + (64'd1 << 23)) >> 24;
        r = 64'd0;
        // largest r with r^5 <= u, one bit at a time
        for (int b = 24; b >= 0; b--) begin
          cand = r | (64'd1 << b);
          p    = cand;
          for (int k = 0; k < 4; k++) begin
            p = (p * cand) >> 24;
          end
          if (p <= u) begin
            r = cand;
          end
        end
        tab[v] = LIN_W'((((r * u) >> 24) + 64'd128) >> 8);
      end
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_TAB = build_gamma();

endpackage

/* rtl/fic_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_lane
// Converts one sRGB color to CIE Lab: gamma table, serial matrix product,
// bit-serial or linear-segment cube root per axis and Lab scaling.
// ----------------------------------------------------------------------------
module fic_lane #(
  parameter int LAB_FRAC_BITS = fic_pkg::LAB_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  output logic             done_o,
  output fic_pkg::lab_vec_t lab_o
);

  localparam int LAB_SHIFT = 16 - LAB_FRAC_BITS;
  localparam int ACC_W     = 35;
  localparam int SQ_W      = 2 * fic_pkg::LIN_W;
  localparam int CUBE_W    = 3 * fic_pkg::LIN_W;
  localparam int V_W       = 28;
  localparam logic [fic_pkg::LIN_W-1:0] LIN_LIMIT = 17'd581;
  localparam logic signed [V_W-1:0] K116 = 28'sd116;
  localparam logic signed [V_W-1:0] K500 = 28'sd500;
  localparam logic signed [V_W-1:0] K200 = 28'sd200;
  localparam logic signed [V_W-1:0] KOFF = 28'sd1048576;
  localparam logic [V_W-1:0] HALF = V_W'(1) << (LAB_SHIFT - 1);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MAT  = 3'd1;
  localparam logic [2:0] L_CSEL = 3'd2;
  localparam logic [2:0] L_CSQ  = 3'd3;
  localparam logic [2:0] L_CMUL = 3'd4;
  localparam logic [2:0] L_LAB  = 3'd5;

  logic [2:0]               state_q, state_d;
  fic_pkg::lin_t            lin_q [3];
  fic_pkg::lin_t            lin_d [3];
  fic_pkg::lin_t            xyz_q [3];
  fic_pkg::lin_t            xyz_d [3];
  fic_pkg::lin_t            f_q [3];
  fic_pkg::lin_t            f_d [3];
  fic_pkg::lab_vec_t        lab_q, lab_d;
  logic [1:0]               row_q, row_d;
  logic [1:0]               col_q, col_d;
  logic [ACC_W-1:0]         acc_q, acc_d;
  fic_pkg::lin_t            res_q, res_d;
  logic [4:0]               bit_q, bit_d;
  logic [SQ_W-1:0]          sq_q, sq_d;
  logic                     done_q, done_d;

  logic [ACC_W-1:0]         prod;
  logic [ACC_W-1:0]         row_sum;
  fic_pkg::lin_t            cand;
  fic_pkg::lin_t            t_cur;
  logic [CUBE_W-1:0]        cube;
  logic [CUBE_W-1:0]        target;
  logic [31:0]              lin_prod;
  fic_pkg::lin_t            f_lin;
  logic signed [V_W-1:0]    fx_e, fy_e, fz_e, v;
  logic [V_W-1:0]           mag, mag_r;
  fic_pkg::lab_t            lab_new;

  // datapath terms
  always_comb begin
    prod     = ACC_W'(fic_pkg::MAT_COEF[row_q][col_q] * lin_q[col_q]);
    row_sum  = acc_q + prod + ACC_W'(16384);
    t_cur    = xyz_q[row_q];
    cand     = res_q | (fic_pkg::lin_t'(1) << bit_q);
    cube     = CUBE_W'(sq_q * cand);
    target   = CUBE_W'({t_cur, 32'd0});
    lin_prod = 32'(t_cur * 17'd31896) + 32'd2048;
    f_lin    = fic_pkg::LIN_W'(lin_prod[31:12]) + fic_pkg::LIN_W'(9039);
    fx_e     = V_W'($signed({1'b0, f_q[0]}));
    fy_e     = V_W'($signed({1'b0, f_q[1]}));
    fz_e     = V_W'($signed({1'b0, f_q[2]}));
    case (row_q)
      2'd0:    v = fy_e * K116 - KOFF;
      2'd1:    v = (fx_e - fy_e) * K500;
      default: v = (fy_e - fz_e) * K200;
    endcase
    // round half away from zero
    mag     = v[V_W-1] ? V_W'(-v) : V_W'(v);
    mag_r   = (mag + HALF) >> LAB_SHIFT;
    lab_new = v[V_W-1] ? -fic_pkg::lab_t'(mag_r) : fic_pkg::lab_t'(mag_r);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    lin_d   = lin_q;
    xyz_d   = xyz_q;
    f_d     = f_q;
    lab_d   = lab_q;
    row_d   = row_q;
    col_d   = col_q;
    acc_d   = acc_q;
    res_d   = res_q;
    bit_d   = bit_q;
    sq_d    = sq_q;
    done_d  = done_q;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          lin_d[0] = fic_pkg::GAMMA_TAB[red_i];
          lin_d[1] = fic_pkg::GAMMA_TAB[green_i];
          lin_d[2] = fic_pkg::GAMMA_TAB[blue_i];
          row_d    = 2'd0;
          col_d    = 2'd0;
          acc_d    = '0;
          done_d   = 1'b0;
          state_d  = L_MAT;
        end
      end
      L_MAT: begin
        if (col_q == 2'd2) begin
          xyz_d[row_q] = row_sum[31:15];
          acc_d        = '0;
          col_d        = 2'd0;
          if (row_q == 2'd2) begin
            row_d   = 2'd0;
            state_d = L_CSEL;
          end else begin
            row_d = row_q + 2'd1;
          end
        end else begin
          acc_d = acc_q + prod;
          col_d = col_q + 2'd1;
        end
      end
      L_CSEL: begin
        if (t_cur < LIN_LIMIT) begin
          f_d[row_q] = f_lin;
          if (row_q == 2'd2) begin
            row_d   = 2'd0;
            state_d = L_LAB;
          end else begin
            row_d = row_q + 2'd1;
          end
        end else begin
          res_d   = '0;
          bit_d   = 5'(fic_pkg::LIN_W - 1);
          state_d = L_CSQ;
        end
      end
      L_CSQ: begin
        sq_d    = SQ_W'(cand * cand);
        state_d = L_CMUL;
      end
      L_CMUL: begin
        if (cube <= target) begin
          res_d = cand;
        end
        if (bit_q == 5'd0) begin
          f_d[row_q] = (cube <= target) ? cand : res_q;
          if (row_q == 2'd2) begin
            row_d   = 2'd0;
            state_d = L_LAB;
          end else begin
            row_d   = row_q + 2'd1;
            state_d = L_CSEL;
          end
        end else begin
          bit_d   = bit_q - 5'd1;
          state_d = L_CSQ;
        end
      end
      L_LAB: begin
        lab_d[row_q] = lab_new;
        if (row_q == 2'd2) begin
          done_d  = 1'b1;
          state_d = L_IDLE;
        end else begin
          row_d = row_q + 2'd1;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lin_q <= lin_d;
    xyz_q <= xyz_d;
    f_q   <= f_d;
    lab_q <= lab_d;
    row_q <= row_d;
    col_q <= col_d;
    acc_q <= acc_d;
    res_q <= res_d;
    bit_q <= bit_d;
    sq_q  <= sq_d;
  end

  assign done_o = done_q;
  assign lab_o  = lab_q;

endmodule

/* rtl/fic_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_merge
// Combines the two lane results: delta E squared against the threshold,
// together with the alpha difference check.
// ----------------------------------------------------------------------------
module fic_merge #(
  parameter int LAB_FRAC_BITS = fic_pkg::LAB_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fic_pkg::lab_vec_t lab_a_i,
  input  fic_pkg::lab_vec_t lab_b_i,
  input  logic [15:0]       thr_i,
  input  logic [7:0]        alpha_a_i,
  input  logic [7:0]        alpha_b_i,
  output fic_pkg::judge_t   res_o
);

  localparam int DIFF_W = fic_pkg::LAB_W + 1;
  localparam int DE2_W  = 2 * fic_pkg::LAB_W + 2;
  localparam int CMP_W  = DE2_W + 16;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SQ   = 2'd1;
  localparam logic [1:0] M_CMP  = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [1:0]               idx_q, idx_d;
  logic [DE2_W-1:0]         de2_q, de2_d;
  fic_pkg::judge_t          res_q, res_d;

  logic signed [DIFF_W-1:0] diff;
  logic [fic_pkg::LAB_W-1:0] mag;
  logic [31:0]              thr2;
  logic [CMP_W-1:0]         lhs, rhs;
  logic [7:0]               ad;
  logic [23:0]              ad_scaled, thr_scaled;

  // per component square, threshold compares
  always_comb begin
    diff       = DIFF_W'(lab_a_i[idx_q]) - DIFF_W'(lab_b_i[idx_q]);
    mag        = diff[DIFF_W-1] ? fic_pkg::LAB_W'(-diff) : fic_pkg::LAB_W'(diff);
    thr2       = 32'(thr_i * thr_i);
    lhs        = {de2_q, 16'd0};
    rhs        = CMP_W'(thr2) << (2 * LAB_FRAC_BITS);
    ad         = (alpha_a_i >= alpha_b_i) ? alpha_a_i - alpha_b_i : alpha_b_i - alpha_a_i;
    ad_scaled  = 24'(ad * 15'd25600);
    thr_scaled = 24'(thr_i * 8'd255);
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    de2_d   = de2_q;
    res_d   = '{done: 1'b0, mismatch: res_q.mismatch};
    unique case (state_q)
      M_IDLE: begin
        if (start_i) begin
          idx_d   = 2'd0;
          de2_d   = '0;
          state_d = M_SQ;
        end
      end
      M_SQ: begin
        de2_d = de2_q + DE2_W'(mag * mag);
        if (idx_q == 2'd2) begin
          state_d = M_CMP;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      M_CMP: begin
        res_d.done     = 1'b1;
        res_d.mismatch = (lhs > rhs) || (ad_scaled > thr_scaled);
        state_d        = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    de2_q <= de2_d;
  end

  assign res_o = res_q;

endmodule

/* rtl/fuzzy_image_compare.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_image_compare
// Streaming fuzzy compare of two RGBA images with a CIE76 delta E test.
// ----------------------------------------------------------------------------
// Identical pixel pairs pass without a stall; differing pairs under the cap
// stall the input while the Lab lanes run a bit-serial cube root (square and
// compare states per result bit, 17 bits per axis above the linear segment,
// three axes in turn). A frame-end pair then stalls the input through S_VR1
// and S_VR2, and S_VR2 loads the verdict word once no earlier verdict stalls.
// Reset restores register defaults and clears the accumulators at once.
module fuzzy_image_compare #(
  parameter int MAX_PIXELS_LOG2 = fic_pkg::MAX_PIXELS_LOG2_DEF,
  parameter int LAB_FRAC_BITS   = fic_pkg::LAB_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_a_i,
  input  logic [7:0]  green_a_i,
  input  logic [7:0]  blue_a_i,
  input  logic [7:0]  alpha_a_i,
  input  logic [7:0]  red_b_i,
  input  logic [7:0]  green_b_i,
  input  logic [7:0]  blue_b_i,
  input  logic [7:0]  alpha_b_i,
  input  logic        frame_end_i,
  // verdict channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        matched_o,
  output logic [22:0] mismatch_count_o,
  output logic [22:0] pixel_total_o,
  output logic [39:0] sum_squared_diff_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
  localparam int SUM_W = MAX_PIXELS_LOG2 + 19;
  localparam int VW    = MAX_PIXELS_LOG2 + 35;
  localparam int DRN_W = CNT_W + 15;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(1) << MAX_PIXELS_LOG2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LAB  = 3'd1;
  localparam logic [2:0] S_DE   = 3'd2;
  localparam logic [2:0] S_VR1  = 3'd3;
  localparam logic [2:0] S_VR2  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [15:0]       delta_e_q;
  logic [15:0]       rms_q;
  logic [14:0]       drift_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  pixel_acc_q, pixel_acc_d;
  logic [CNT_W-1:0]  mismatch_acc_q, mismatch_acc_d;
  logic [7:0]        alpha_a_q, alpha_b_q;
  logic              frame_end_q;
  logic [31:0]       rms2_q;
  logic [DRN_W-1:0]  drift_n_q;
  logic              out_valid_q, out_valid_d;
  logic              matched_q;
  logic [22:0]       mcount_q;
  logic [22:0]       ptotal_q;
  logic [39:0]       ssd_q;

  logic              accept;
  logic              in_range;
  logic              differ;
  logic [17:0]       sq4;
  logic              lane_start;
  logic              merge_start;
  logic              lane_done_a, lane_done_b;
  fic_pkg::lab_vec_t lab_a, lab_b;
  fic_pkg::judge_t   judge;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic [VW-1:0]     rms_lhs, rms_rhs;
  logic [DRN_W-1:0]  drift_lhs;
  logic              slot_free;
  logic              load_out;
  logic [63:0]       pix_ext, mis_ext, sum_ext;
  logic [7:0]        ch_a [4];
  logic [7:0]        ch_b [4];
  logic [7:0]        ch_d [4];

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      fic_pkg::REG_DELTA_E: prdata = {16'd0, delta_e_q};
      fic_pkg::REG_RMS:     prdata = {16'd0, rms_q};
      fic_pkg::REG_DRIFT:   prdata = {17'd0, drift_q};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_e_q <= fic_pkg::DELTA_E_RST;
      rms_q     <= fic_pkg::RMS_RST;
      drift_q   <= fic_pkg::DRIFT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fic_pkg::REG_DELTA_E: delta_e_q <= pwdata[15:0];
        fic_pkg::REG_RMS:     rms_q     <= pwdata[15:0];
        fic_pkg::REG_DRIFT:   drift_q   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // squared channel differences of the incoming pair
  always_comb begin
    ch_a   = '{red_a_i, green_a_i, blue_a_i, alpha_a_i};
    ch_b   = '{red_b_i, green_b_i, blue_b_i, alpha_b_i};
    sq4    = '0;
    differ = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ch_d[i] = (ch_a[i] >= ch_b[i]) ? ch_a[i] - ch_b[i] : ch_b[i] - ch_a[i];
      sq4     = sq4 + 18'(ch_d[i] * ch_d[i]);
      differ  = differ || (ch_d[i] != 8'd0);
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = pixel_acc_q < CAP;
  assign lane_start = accept && in_range && differ;

  // Lab lanes, one per image
  fic_lane #(.LAB_FRAC_BITS(LAB_FRAC_BITS)) u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .red_i   (red_a_i),
    .green_i (green_a_i),
    .blue_i  (blue_a_i),
    .done_o  (lane_done_a),
    .lab_o   (lab_a)
  );

  fic_lane #(.LAB_FRAC_BITS(LAB_FRAC_BITS)) u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .red_i   (red_b_i),
    .green_i (green_b_i),
    .blue_i  (blue_b_i),
    .done_o  (lane_done_b),
    .lab_o   (lab_b)
  );

  fic_merge #(.LAB_FRAC_BITS(LAB_FRAC_BITS)) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (merge_start),
    .lab_a_i   (lab_a),
    .lab_b_i   (lab_b),
    .thr_i     (delta_e_q),
    .alpha_a_i (alpha_a_q),
    .alpha_b_i (alpha_b_q),
    .res_o     (judge)
  );

  // verdict compares
  always_comb begin
    rms_lhs   = {sum_q, 16'd0};
    rms_rhs   = VW'({rms2_q, 2'b00} * pixel_acc_q);
    drift_lhs = DRN_W'(mismatch_acc_q * 15'd25600);
    slot_free = !out_valid_q || !out_stall_i;
    pix_ext   = 64'(pixel_acc_q);
    mis_ext   = 64'(mismatch_acc_q);
    sum_ext   = 64'(sum_q);
  end

  // control sequence
  always_comb begin
    state_d        = state_q;
    sum_d          = sum_q;
    pixel_acc_d    = pixel_acc_q;
    mismatch_acc_d = mismatch_acc_q;
    merge_start    = 1'b0;
    load_out       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_range) begin
            sum_d       = sum_q + SUM_W'(sq4);
            pixel_acc_d = pixel_acc_q + CNT_W'(1);
          end
          if (lane_start) begin
            state_d = S_LAB;
          end else if (frame_end_i) begin
            state_d = S_VR1;
          end
        end
      end
      S_LAB: begin
        if (lane_done_a && lane_done_b) begin
          merge_start = 1'b1;
          state_d     = S_DE;
        end
      end
      S_DE: begin
        if (judge.done) begin
          mismatch_acc_d = mismatch_acc_q + CNT_W'(judge.mismatch);
          state_d        = frame_end_q ? S_VR1 : S_IDLE;
        end
      end
      S_VR1: state_d = S_VR2;
      S_VR2: begin
        if (slot_free) begin
          load_out       = 1'b1;
          sum_d          = '0;
          pixel_acc_d    = '0;
          mismatch_acc_d = '0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      sum_q          <= '0;
      pixel_acc_q    <= '0;
      mismatch_acc_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      sum_q          <= sum_d;
      pixel_acc_q    <= pixel_acc_d;
      mismatch_acc_q <= mismatch_acc_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      alpha_a_q   <= alpha_a_i;
      alpha_b_q   <= alpha_b_i;
      frame_end_q <= frame_end_i;
    end
    if (state_q == S_VR1) begin
      rms2_q    <= 32'(rms_q * rms_q);
      drift_n_q <= DRN_W'(drift_q * pixel_acc_q);
    end
    if (load_out) begin
      matched_q <= !(rms_lhs > rms_rhs) && !(drift_lhs > drift_n_q);
      mcount_q  <= mis_ext[22:0];
      ptotal_q  <= pix_ext[22:0];
      ssd_q     <= sum_ext[39:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign mismatch_count_o   = mcount_q;
  assign pixel_total_o      = ptotal_q;
  assign sum_squared_diff_o = ssd_q;

  // checks
  a_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_acc_q <= CAP) else $error("pixel count past cap");

  a_mis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mismatch_acc_q <= pixel_acc_q) else $error("more mismatches than pixels");

  a_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_VR2)
    else $error("verdict word raised outside verdict state");

  a_lanes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DE |-> lane_done_a && lane_done_b)
    else $error("merge running without lane results");

endmodule
